// ----- sv/pgmsp_pkg.sv -----
// ----------------------------------------------------------------------------
// PGM stream parser package
// Shared types and character constants for the binary greyscale image parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pgmsp_pkg;

  typedef enum logic [3:0] {
    PH_WAIT_P    = 4'd0,
    PH_WAIT_5    = 4'd1,
    PH_SEP       = 4'd2,
    PH_W_FIRST   = 4'd3,
    PH_W_COMMENT = 4'd4,
    PH_W_DIGITS  = 4'd5,
    PH_H_DIGITS  = 4'd6,
    PH_M_FIRST   = 4'd7,
    PH_M_COMMENT = 4'd8,
    PH_M_DIGITS  = 4'd9,
    PH_PIXELS    = 4'd10,
    PH_DONE      = 4'd11,
    PH_ERROR     = 4'd12
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_IGNORE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_MAGIC  = 2'd0,
    ERR_MAXVAL = 2'd1,
    ERR_DIM    = 2'd2
  } err_t;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [8:0] MAXVAL_OK = 9'd255;

  // Parser state apart from the two dimension accumulators.
  typedef struct packed {
    phase_t      phase;
    logic [8:0]  maxval;
    logic [11:0] col;
    logic [11:0] row;
  } pgmsp_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  pixel;
    logic [11:0] col;
    logic [11:0] row;
    logic        last;
    err_t        err;
  } pgmsp_result_t;

endpackage

`default_nettype wire

// ----- sv/pgmsp_step.sv -----
// ----------------------------------------------------------------------------
// PGM stream parser step
// Combinational next-state and result logic for one byte of the file.
// ----------------------------------------------------------------------------
`default_nettype none

module pgmsp_step #(
  parameter int DIM_W   = 13,
  parameter int MAX_DIM = 4096
) (
  input  wire logic [7:0]           data_byte,
  input  wire logic                 start_of_file,
  input  wire pgmsp_pkg::pgmsp_state_t state,
  input  wire logic [DIM_W-1:0]     width_acc,
  input  wire logic [DIM_W-1:0]     height_acc,
  output pgmsp_pkg::pgmsp_state_t   state_next,
  output logic [DIM_W-1:0]          width_acc_next,
  output logic [DIM_W-1:0]          height_acc_next,
  output pgmsp_pkg::pgmsp_result_t  result
);
  import pgmsp_pkg::*;

  localparam int VW = DIM_W + 4;
  localparam int CW = (DIM_W > 13) ? DIM_W : 13;
  localparam logic [VW-1:0] MAX_V = VW'(MAX_DIM);

  pgmsp_state_t     cur;
  logic [DIM_W-1:0] w_cur;
  logic [DIM_W-1:0] h_cur;
  logic             is_digit;
  logic [3:0]       digit;
  logic [VW-1:0]    w_prod;
  logic [VW-1:0]    h_prod;
  logic [12:0]      m_prod;
  logic [12:0]      col_inc;
  logic [12:0]      row_inc;
  logic [CW-1:0]    col_inc_ext;
  logic [CW-1:0]    row_inc_ext;
  logic [CW-1:0]    width_ext;
  logic [CW-1:0]    height_ext;
  pgmsp_state_t     nxt;
  pgmsp_result_t    res;

  // A start flag restarts parsing on this very byte.
  always_comb begin
    if (start_of_file) begin
      cur.phase  = PH_WAIT_P;
      cur.maxval = '0;
      cur.col    = '0;
      cur.row    = '0;
      w_cur      = '0;
      h_cur      = '0;
    end else begin
      cur   = state;
      w_cur = width_acc;
      h_cur = height_acc;
    end
  end

  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign digit    = 4'(data_byte - CH_ZERO);

  // Multiply by ten as two shifts and an add.
  assign w_prod = (VW'(w_cur) << 3) + (VW'(w_cur) << 1) + VW'(digit);
  assign h_prod = (VW'(h_cur) << 3) + (VW'(h_cur) << 1) + VW'(digit);
  assign m_prod = (13'(cur.maxval) << 3) + (13'(cur.maxval) << 1) + 13'(digit);

  assign col_inc     = 13'(cur.col) + 13'd1;
  assign row_inc     = 13'(cur.row) + 13'd1;
  assign col_inc_ext = CW'(col_inc);
  assign row_inc_ext = CW'(row_inc);
  assign width_ext   = CW'(w_cur);
  assign height_ext  = CW'(h_cur);

  always_comb begin
    nxt             = cur;
    width_acc_next  = w_cur;
    height_acc_next = h_cur;
    res             = '0;
    res.kind        = KIND_HEADER;
    res.err         = ERR_MAGIC;
    case (cur.phase)
      PH_WAIT_P: begin
        if (data_byte == CH_P) nxt.phase = PH_WAIT_5;
        else begin
          res.kind = KIND_ERROR;
          res.err  = ERR_MAGIC;
        end
      end
      PH_WAIT_5: begin
        if (data_byte == CH_5) nxt.phase = PH_SEP;
        else begin
          res.kind = KIND_ERROR;
          res.err  = ERR_MAGIC;
        end
      end
      PH_SEP: nxt.phase = PH_W_FIRST;
      PH_W_COMMENT: begin
        if (data_byte == CH_NL) nxt.phase = PH_W_DIGITS;
      end
      PH_M_COMMENT: begin
        if (data_byte == CH_NL) nxt.phase = PH_M_DIGITS;
      end
      PH_W_FIRST, PH_W_DIGITS: begin
        if (cur.phase == PH_W_FIRST && data_byte == CH_HASH) begin
          nxt.phase = PH_W_COMMENT;
        end else if (data_byte == CH_SPACE) begin
          if (w_cur == '0) begin
            res.kind = KIND_ERROR;
            res.err  = ERR_DIM;
          end else begin
            nxt.phase = PH_H_DIGITS;
          end
        end else if (!is_digit || w_prod > MAX_V) begin
          res.kind = KIND_ERROR;
          res.err  = ERR_DIM;
        end else begin
          width_acc_next = w_prod[DIM_W-1:0];
          nxt.phase      = PH_W_DIGITS;
        end
      end
      PH_H_DIGITS: begin
        if (data_byte == CH_NL) begin
          if (h_cur == '0) begin
            res.kind = KIND_ERROR;
            res.err  = ERR_DIM;
          end else begin
            nxt.phase = PH_M_FIRST;
          end
        end else if (!is_digit || h_prod > MAX_V) begin
          res.kind = KIND_ERROR;
          res.err  = ERR_DIM;
        end else begin
          height_acc_next = h_prod[DIM_W-1:0];
        end
      end
      PH_M_FIRST, PH_M_DIGITS: begin
        if (cur.phase == PH_M_FIRST && data_byte == CH_HASH) begin
          nxt.phase = PH_M_COMMENT;
        end else if (data_byte == CH_NL) begin
          if (cur.maxval != MAXVAL_OK) begin
            res.kind = KIND_ERROR;
            res.err  = ERR_MAXVAL;
          end else begin
            nxt.phase = PH_PIXELS;
          end
        end else if (is_digit && m_prod <= 13'(MAXVAL_OK)) begin
          nxt.maxval = m_prod[8:0];
          nxt.phase  = PH_M_DIGITS;
        end else begin
          res.kind = KIND_ERROR;
          res.err  = ERR_MAXVAL;
        end
      end
      PH_PIXELS: begin
        res.kind  = KIND_PIXEL;
        res.pixel = data_byte;
        res.col   = cur.col;
        res.row   = cur.row;
        if (col_inc_ext >= width_ext) begin
          nxt.col = '0;
          if (row_inc_ext >= height_ext) begin
            res.last  = 1'b1;
            nxt.phase = PH_DONE;
          end else begin
            nxt.row = row_inc[11:0];
          end
        end else begin
          nxt.col = col_inc[11:0];
        end
      end
      default: res.kind = KIND_IGNORE;
    endcase
    if (res.kind == KIND_ERROR) nxt.phase = PH_ERROR;
  end

  assign state_next = nxt;
  assign result     = res;

endmodule

`default_nettype wire

// ----- sv/pgm_binary_stream_parser.sv -----
// ----------------------------------------------------------------------------
// PGM binary stream parser
// Parses a P5 greyscale image file byte by byte and reports every pixel.
// ----------------------------------------------------------------------------
// Bytes of the file enter on the slave channel, one per request; tuser set
// marks the first byte of a new file and restarts the parser on that byte.
// Every byte gives exactly one result request on the master channel: a header
// byte, a pixel with its column and row, an error with its code, or an
// ignored byte. tlast marks the final pixel of the image. After an error or
// the last pixel, bytes are ignored until the next start flag.
// The header fields are decoded in combinational logic between the accepted
// byte and the result register; one byte can be taken on every clock while
// the receiver keeps up. The result register frees up in the same cycle in
// which the receiver takes its contents, so a stalled receiver only holds off
// the input while a result is waiting, and no byte is lost or repeated.
// The synchronous reset empties the result register and returns the parser
// to waiting for the magic; parsing also begins without a start flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pgm_binary_stream_parser #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] start_of_file
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] pixel_value, [19:8] col, [31:20] row, [44:32] image_width,
  // [57:45] image_height, [59:58] error_code, [63:60] zero
  output logic [63:0]      m_axis_tdata,
  output logic             m_axis_tlast,   // last_pixel
  output logic [1:0]       m_axis_tuser    // [1:0] kind
);
  import pgmsp_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int EW    = (DIM_W > 13) ? DIM_W : 13;

  pgmsp_state_t     state;
  pgmsp_state_t     state_next;
  logic [DIM_W-1:0] width_acc;
  logic [DIM_W-1:0] width_acc_next;
  logic [DIM_W-1:0] height_acc;
  logic [DIM_W-1:0] height_acc_next;
  pgmsp_result_t    step_result;
  pgmsp_result_t    out_result;
  logic [EW-1:0]    width_ext;
  logic [EW-1:0]    height_ext;
  logic [12:0]      out_width;
  logic [12:0]      out_height;
  logic             out_valid;
  logic             accept;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  pgmsp_step #(
    .DIM_W   (DIM_W),
    .MAX_DIM (MAX_DIM)
  ) u_step (
    .data_byte       (s_axis_tdata),
    .start_of_file   (s_axis_tuser),
    .state           (state),
    .width_acc       (width_acc),
    .height_acc      (height_acc),
    .state_next      (state_next),
    .width_acc_next  (width_acc_next),
    .height_acc_next (height_acc_next),
    .result          (step_result)
  );

  assign width_ext  = EW'(width_acc_next);
  assign height_ext = EW'(height_acc_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase  <= PH_WAIT_P;
      state.maxval <= '0;
      state.col    <= '0;
      state.row    <= '0;
      width_acc    <= '0;
      height_acc   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        state      <= state_next;
        width_acc  <= width_acc_next;
        height_acc <= height_acc_next;
        out_valid  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_result <= step_result;
      out_width  <= width_ext[12:0];
      out_height <= height_ext[12:0];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0, out_result.err, out_height, out_width,
                          out_result.row, out_result.col, out_result.pixel};
  assign m_axis_tlast  = out_result.last;
  assign m_axis_tuser  = out_result.kind;

endmodule

`default_nettype wire

// ----- sv/pgmsp_checker.sv -----
// ----------------------------------------------------------------------------
// PGM stream parser checker
// Port-level assertions on the parser's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pgmsp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic [1:0]  m_axis_tuser
);
  import pgmsp_pkg::*;

  // Every accepted byte leaves a result request behind it.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted byte produced no result");

  // With nothing held in the result register the input must be open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty result register");

  a_last_is_pixel: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_PIXEL)
    else $error("last marker on a result that is not a pixel");

  // Pixel, column and row are zero on every result that is not a pixel.
  a_nonpixel_clear: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != KIND_PIXEL |-> m_axis_tdata[31:0] == 32'd0)
    else $error("pixel fields set on a non-pixel result");

  a_error_code_clear: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != KIND_ERROR |-> m_axis_tdata[59:58] == 2'd0)
    else $error("error code set on a result that is not an error");

endmodule

bind pgm_binary_stream_parser pgmsp_checker u_pgmsp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
